[rtl/packet_deframer_checksum_top_defines.svh]
// Assertion macros for the packet deframer.
`ifndef PACKET_DEFRAMER_CHECKSUM_TOP_DEFINES_SVH
`define PACKET_DEFRAMER_CHECKSUM_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
`define PDC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pdc assertion failed");
`define PDC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pdc assertion failed");
`else
`define PDC_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define PDC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

[rtl/pdc_pkg.sv]
package pdc_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned INDEX_W    = 9;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned CFG_ADDR_W = 2;

  localparam int unsigned HEADER_BYTES = 2;

  localparam logic [CFG_ADDR_W-1:0] CFG_HEAD_BYTE = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_END_BYTE  = 2'd1;

  localparam logic [STATUS_W-1:0] ST_BUSY    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_GOOD    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_END = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_SUM = 2'd3;

  typedef enum logic [4:0] {
    PH_IDLE     = 5'b00001,
    PH_LENGTH   = 5'b00010,
    PH_BODY     = 5'b00100,
    PH_END      = 5'b01000,
    PH_CHECKSUM = 5'b10000
  } phase_t;

endpackage

[rtl/pdc_ifs.sv]
interface pdc_rx_if;
  logic                          valid;
  logic                          ready;
  logic [pdc_pkg::BYTE_W-1:0]    rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface pdc_result_if;
  logic                          valid;
  logic                          ready;
  logic                          store_valid;
  logic [pdc_pkg::INDEX_W-1:0]   store_index;
  logic [pdc_pkg::BYTE_W-1:0]    store_data;
  logic [pdc_pkg::STATUS_W-1:0]  frame_status;

  modport source (output valid, output store_valid, output store_index,
                  output store_data, output frame_status, input ready);
  modport sink   (input valid, input store_valid, input store_index,
                  input store_data, input frame_status, output ready);
endinterface

interface pdc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [pdc_pkg::CFG_ADDR_W-1:0] index;
  logic [pdc_pkg::BYTE_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/packet_deframer_checksum_top.sv]
// Byte-stream deframer: one received byte per transfer on rx, one result per byte on res.
// Frames are head, length, length body bytes, end, checksum; head, length and body bytes
// come out as store strobes with their buffer index (head at 0), and the frame status
// reports good, bad end byte or bad checksum on the byte that decides it. A result
// appears in the cycle after its byte is taken; the block takes one byte every clock as
// long as the result register is empty or being drained in the same cycle. The user must
// write the head and end byte values on cfg (index 0, 1) only while idle; not enforced.
`include "packet_deframer_checksum_top_defines.svh"

module packet_deframer_checksum_top (
  input  logic             clk,
  input  logic             rst,
  pdc_rx_if.sink           rx,
  pdc_result_if.source     res,
  pdc_cfg_if.sink          cfg
);

  localparam int unsigned BW = pdc_pkg::BYTE_W;
  localparam int unsigned IW = pdc_pkg::INDEX_W;
  localparam int unsigned SW = pdc_pkg::STATUS_W;

  logic [BW-1:0]   head_byte;
  logic [BW-1:0]   end_byte;

  pdc_pkg::phase_t phase, phase_next;
  logic [IW-1:0]   count, count_next;
  logic [BW-1:0]   sum, sum_next;
  logic [BW-1:0]   len, len_next;

  logic            out_valid;
  logic            out_store_valid;
  logic [IW-1:0]   out_store_index;
  logic [BW-1:0]   out_store_data;
  logic [SW-1:0]   out_status;

  logic            st_valid;
  logic [IW-1:0]   st_index;
  logic [BW-1:0]   st_data;
  logic [SW-1:0]   status;
  logic            restart;
  logic            rx_take;
  logic [BW-1:0]   b;
  logic [IW-1:0]   count_inc;
  logic [IW-1:0]   body_last;

  assign cfg.ready = 1'b1;
  assign rx.ready  = !out_valid || res.ready;
  assign rx_take   = rx.valid && rx.ready;
  assign b         = rx.rx_byte;

  assign count_inc = count + IW'(1);
  assign body_last = {1'b0, len} + IW'(pdc_pkg::HEADER_BYTES);

  always_ff @(posedge clk) begin
    if (rst) begin
      head_byte <= '0;
      end_byte  <= '0;
    end else if (cfg.valid && cfg.ready) begin
      if (cfg.index == pdc_pkg::CFG_HEAD_BYTE) begin
        head_byte <= cfg.data;
      end else if (cfg.index == pdc_pkg::CFG_END_BYTE) begin
        end_byte <= cfg.data;
      end
    end
  end

  always_comb begin
    st_valid   = 1'b0;
    st_index   = '0;
    st_data    = '0;
    status     = pdc_pkg::ST_BUSY;
    restart    = 1'b0;
    phase_next = phase;
    count_next = count;
    sum_next   = sum;
    len_next   = len;
    unique case (phase)
      pdc_pkg::PH_LENGTH: begin
        len_next   = b;
        st_valid   = 1'b1;
        st_index   = count;
        st_data    = b;
        count_next = count_inc;
        sum_next   = sum + b;
        phase_next = (b == '0) ? pdc_pkg::PH_END : pdc_pkg::PH_BODY;
      end
      pdc_pkg::PH_BODY: begin
        st_valid   = 1'b1;
        st_index   = count;
        st_data    = b;
        count_next = count_inc;
        sum_next   = sum + b;
        if (count_inc == body_last) begin
          phase_next = pdc_pkg::PH_END;
        end
      end
      pdc_pkg::PH_END: begin
        if (b == end_byte) begin
          sum_next   = sum + b;
          phase_next = pdc_pkg::PH_CHECKSUM;
        end else begin
          status  = pdc_pkg::ST_BAD_END;
          restart = 1'b1;
        end
      end
      pdc_pkg::PH_CHECKSUM: begin
        if (b == BW'(~sum + BW'(1))) begin
          status     = pdc_pkg::ST_GOOD;
          phase_next = pdc_pkg::PH_IDLE;
        end else begin
          status  = pdc_pkg::ST_BAD_SUM;
          restart = 1'b1;
        end
      end
      default: begin
        restart = 1'b1;
      end
    endcase
    // re-examine the byte as a new head
    if (restart) begin
      phase_next = pdc_pkg::PH_IDLE;
      if (b == head_byte) begin
        st_valid   = 1'b1;
        st_index   = '0;
        st_data    = b;
        count_next = IW'(1);
        sum_next   = b;
        phase_next = pdc_pkg::PH_LENGTH;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= pdc_pkg::PH_IDLE;
      count <= '0;
      sum   <= '0;
      len   <= '0;
    end else if (rx_take) begin
      phase <= phase_next;
      count <= count_next;
      sum   <= sum_next;
      len   <= len_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rx.ready) begin
      out_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_take) begin
      out_store_valid <= st_valid;
      out_store_index <= st_index;
      out_store_data  <= st_data;
      out_status      <= status;
    end
  end

  assign res.valid        = out_valid;
  assign res.store_valid  = out_store_valid;
  assign res.store_index  = out_store_index;
  assign res.store_data   = out_store_data;
  assign res.frame_status = out_status;

  `PDC_ASSERT_IMPLY(a_good_no_store, clk, rst, res.valid && res.frame_status == pdc_pkg::ST_GOOD, !res.store_valid)
  `PDC_ASSERT_IMPLY(a_idle_fields_zero, clk, rst, res.valid && !res.store_valid, res.store_index == '0 && res.store_data == '0)
  `PDC_ASSERT_NEXT(a_length_step, clk, rst, rx_take && phase == pdc_pkg::PH_LENGTH, phase == pdc_pkg::PH_END || phase == pdc_pkg::PH_BODY)
  `PDC_ASSERT_NEXT(a_head_opens, clk, rst, rx_take && st_valid && st_index == '0, phase == pdc_pkg::PH_LENGTH && count == IW'(1))

endmodule

[tb/sv/deframe_scoreboard.sv]
`timescale 1ns / 100ps

module deframe_scoreboard
  import pdc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  pdc_rx_if           rx,
  pdc_result_if       res,
  pdc_cfg_if          cfg,
  output int unsigned mismatches,
  output int unsigned outstanding
);

  typedef struct packed {
    logic                store_valid;
    logic [INDEX_W-1:0]  store_index;
    logic [BYTE_W-1:0]   store_data;
    logic [STATUS_W-1:0] frame_status;
  } deframe_result_t;

  logic [BYTE_W-1:0]  head_reg;
  logic [BYTE_W-1:0]  end_reg;
  phase_t             phase;
  logic [INDEX_W-1:0] byte_count;
  logic [BYTE_W-1:0]  running_sum;
  logic [BYTE_W-1:0]  body_length;

  deframe_result_t due_results[$];

  function automatic deframe_result_t deframe_byte(input logic [BYTE_W-1:0] b);
    deframe_result_t   r;
    logic              keep;
    logic              hunt;
    logic              in_body;
    logic [BYTE_W-1:0] closing;
    r = '0;
    r.frame_status = ST_BUSY;
    keep = 1'b0;
    hunt = 1'b0;
    in_body = (phase == PH_BODY);
    closing = ~running_sum + 1'b1;
    case (phase)
      PH_LENGTH: begin
        body_length = b;
        keep = 1'b1;
        phase = (b == '0) ? PH_END : PH_BODY;
      end
      PH_BODY: keep = 1'b1;
      PH_END: begin
        if (b == end_reg) begin
          running_sum = running_sum + b;
          phase = PH_CHECKSUM;
        end else begin
          r.frame_status = ST_BAD_END;
          hunt = 1'b1;
        end
      end
      PH_CHECKSUM: begin
        if (b == closing) begin
          r.frame_status = ST_GOOD;
          phase = PH_IDLE;
        end else begin
          r.frame_status = ST_BAD_SUM;
          hunt = 1'b1;
        end
      end
      default: hunt = 1'b1;
    endcase
    // a rejected byte may open the next frame
    if (hunt) begin
      phase = PH_IDLE;
      if (b == head_reg) begin
        byte_count = '0;
        running_sum = '0;
        keep = 1'b1;
        phase = PH_LENGTH;
      end
    end
    if (keep) begin
      r.store_valid = 1'b1;
      r.store_index = byte_count;
      r.store_data = b;
      byte_count = byte_count + 1'b1;
      running_sum = running_sum + b;
    end
    if (in_body && (INDEX_W'(body_length) + INDEX_W'(HEADER_BYTES)) == byte_count) begin
      phase = PH_END;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    deframe_result_t seen;
    deframe_result_t want;
    if (rst) begin
      head_reg = '0;
      end_reg = '0;
      phase = PH_IDLE;
      byte_count = '0;
      running_sum = '0;
      body_length = '0;
      due_results.delete();
      mismatches = 0;
    end else begin
      if (res.valid && res.ready) begin
        seen.store_valid = res.store_valid;
        seen.store_index = res.store_index;
        seen.store_data = res.store_data;
        seen.frame_status = res.frame_status;
        if (due_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("[%0t] unexpected result: store=%0b index=%0d data=%02h status=%0d",
                     $time, seen.store_valid, seen.store_index, seen.store_data,
                     seen.frame_status);
          end
        end else begin
          want = due_results.pop_front();
          if (seen.store_valid !== want.store_valid ||
              seen.store_index !== want.store_index ||
              seen.store_data !== want.store_data ||
              seen.frame_status !== want.frame_status) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("[%0t] result mismatch: expected store=%0b index=%0d data=%02h status=%0d",
                       $time, want.store_valid, want.store_index, want.store_data,
                       want.frame_status);
              $display("[%0t]                  got      store=%0b index=%0d data=%02h status=%0d",
                       $time, seen.store_valid, seen.store_index, seen.store_data,
                       seen.frame_status);
            end
          end
        end
      end
      if (rx.valid && rx.ready) begin
        due_results.push_back(deframe_byte(rx.rx_byte));
      end
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CFG_HEAD_BYTE: head_reg = cfg.data;
          CFG_END_BYTE:  end_reg = cfg.data;
          default: ;
        endcase
      end
    end
    outstanding = due_results.size();
  end

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 100ps

module testbench;
  import pdc_pkg::*;

  localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_HI = 2'd3;
  localparam int PHASE_ITEMS = 100;
  localparam int MAX_BODY    = 255;
  localparam int STALL_LIMIT = 1000;

  // 7E 01 84 7F closes with checksum 7E under head 7E, end 7F
  localparam logic [BYTE_W-1:0] CLOSING_ON_HEAD [5] = '{8'h7E, 8'h01, 8'h84, 8'h7F, 8'h7E};

  typedef enum {
    FRAME_GOOD,
    FRAME_BAD_END,
    FRAME_BAD_END_HEAD,
    FRAME_BAD_SUM,
    FRAME_BAD_SUM_HEAD,
    FRAME_CUT
  } frame_kind_t;

  logic clk = 1'b0;
  logic rst;

  pdc_rx_if     rx_chan ();
  pdc_result_if res_chan ();
  pdc_cfg_if    cfg_chan ();

  int unsigned mismatches;
  int unsigned outstanding;

  int items_sent;
  int burst_left;
  int stall_left;
  int calm_left;
  int idle_cycles;

  logic [BYTE_W-1:0] cur_head;
  logic [BYTE_W-1:0] cur_end;

  packet_deframer_checksum_top uut (
    .clk (clk),
    .rst (rst),
    .rx  (rx_chan),
    .res (res_chan),
    .cfg (cfg_chan)
  );

  deframe_scoreboard scoreboard (
    .clk         (clk),
    .rst         (rst),
    .rx          (rx_chan),
    .res         (res_chan),
    .cfg         (cfg_chan),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst) begin
      res_chan.ready <= 1'b0;
      stall_left = 0;
      calm_left = 0;
    end else if (calm_left > 0) begin
      calm_left--;
      res_chan.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      res_chan.ready <= 1'b0;
    end else begin
      case ($urandom_range(0, 15))
        0: begin
          calm_left = $urandom_range(30, 150);
          res_chan.ready <= 1'b1;
        end
        1, 2, 3: begin
          stall_left = $urandom_range(0, 11);
          res_chan.ready <= 1'b0;
        end
        default: res_chan.ready <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst || (rx_chan.valid && rx_chan.ready) || (res_chan.valid && res_chan.ready) ||
        (cfg_chan.valid && cfg_chan.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_rx_byte(input logic [BYTE_W-1:0] b);
    rx_chan.valid <= 1'b1;
    rx_chan.rx_byte <= b;
    @(posedge clk);
    while (!rx_chan.ready) @(posedge clk);
    items_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      rx_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 90) : $urandom_range(1, 12);
    end
  endtask

  task automatic sender_hold();
    if (rx_chan.valid) rx_chan.valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [BYTE_W-1:0] val);
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= idx;
    cfg_chan.data <= val;
    @(posedge clk);
    while (!cfg_chan.ready) @(posedge clk);
    cfg_chan.valid <= 1'b0;
    @(posedge clk);
    if (idx == CFG_HEAD_BYTE) cur_head = val;
    else if (idx == CFG_END_BYTE) cur_end = val;
  endtask

  task automatic send_frame(input int len, input frame_kind_t kind, input bit with_head);
    logic [BYTE_W-1:0] bytes_q[$];
    logic [BYTE_W-1:0] sum;
    logic [BYTE_W-1:0] b;
    logic [BYTE_W-1:0] good;
    bit                restart;
    int                last;
    restart = 1'b0;
    sum = cur_head + 8'(len);
    if (with_head) bytes_q.push_back(cur_head);
    bytes_q.push_back(8'(len));
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom);
      bytes_q.push_back(b);
      sum += b;
    end
    if (kind == FRAME_BAD_END || kind == FRAME_BAD_END_HEAD) begin
      b = (kind == FRAME_BAD_END_HEAD && cur_head != cur_end) ? cur_head : 8'($urandom);
      if (b == cur_end) b = b ^ 8'h01;
      bytes_q.push_back(b);
      restart = (b == cur_head);
    end else begin
      bytes_q.push_back(cur_end);
      sum += cur_end;
      good = ~sum + 8'd1;
      b = good;
      if (kind == FRAME_BAD_SUM || kind == FRAME_BAD_SUM_HEAD) begin
        b = (kind == FRAME_BAD_SUM_HEAD && cur_head != good) ? cur_head : 8'($urandom);
        if (b == good) b = b ^ 8'h80;
        restart = (b == cur_head);
      end
      bytes_q.push_back(b);
    end
    if (kind == FRAME_CUT) begin
      last = $urandom_range(0, bytes_q.size() - 2);
      bytes_q = bytes_q[0:last];
    end
    foreach (bytes_q[i]) send_rx_byte(bytes_q[i]);
    // the rejected byte reopened a frame: finish it
    if (restart) send_frame(len, FRAME_GOOD, 1'b0);
  endtask

  task automatic run_phase(input logic [BYTE_W-1:0] head, input logic [BYTE_W-1:0] endb,
                           input bit long_frame);
    int target;
    int len;
    int pick;
    sender_hold();
    write_reg(CFG_HEAD_BYTE, head);
    write_reg(CFG_END_BYTE, endb);
    target = items_sent + PHASE_ITEMS;
    if (long_frame) send_frame(MAX_BODY, FRAME_GOOD, 1'b1);
    while (items_sent < target) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
      pick = $urandom_range(0, 99);
      if (pick < 40) send_frame(len, FRAME_GOOD, 1'b1);
      else if (pick < 50) send_frame(len, FRAME_BAD_END, 1'b1);
      else if (pick < 58) send_frame(len, FRAME_BAD_END_HEAD, 1'b1);
      else if (pick < 68) send_frame(len, FRAME_BAD_SUM, 1'b1);
      else if (pick < 76) send_frame(len, FRAME_BAD_SUM_HEAD, 1'b1);
      else if (pick < 86) send_frame(len, FRAME_CUT, 1'b1);
      else begin
        repeat ($urandom_range(1, 6))
          send_rx_byte(($urandom_range(0, 3) == 0) ? cur_head : 8'($urandom));
      end
    end
  endtask

  initial begin
    rst <= 1'b1;
    rx_chan.valid <= 1'b0;
    rx_chan.rx_byte <= '0;
    cfg_chan.valid <= 1'b0;
    cfg_chan.index <= '0;
    cfg_chan.data <= '0;
    items_sent = 0;
    burst_left = 40;
    cur_head = '0;
    cur_end = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // registers at reset value: an all-zero, zero-length frame
    send_frame(0, FRAME_GOOD, 1'b1);
    sender_hold();
    write_reg(CFG_HEAD_BYTE, 8'h7E);
    write_reg(CFG_END_BYTE, 8'h7F);
    foreach (CLOSING_ON_HEAD[i]) send_rx_byte(CLOSING_ON_HEAD[i]);
    send_frame(0, FRAME_BAD_END_HEAD, 1'b1);
    send_frame(1, FRAME_BAD_SUM, 1'b1);
    send_frame(0, FRAME_BAD_SUM_HEAD, 1'b1);
    send_frame(2, FRAME_BAD_END, 1'b1);

    run_phase(8'h00, 8'hFF, 1'b0);
    run_phase(8'hFF, 8'h00, 1'b1);
    run_phase(8'h55, 8'h55, 1'b0);
    sender_hold();
    write_reg(CFG_SPARE_LO, 8'($urandom));
    write_reg(CFG_SPARE_HI, 8'($urandom));
    run_phase(8'($urandom), 8'($urandom), 1'b0);
    run_phase(8'h7E, 8'h7F, 1'b0);
    run_phase(8'($urandom), 8'($urandom), 1'b0);
    run_phase(8'h01, 8'h80, 1'b0);
    run_phase(8'($urandom), 8'($urandom), 1'b0);

    sender_hold();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
